@@ rtl/core/srtp_pkg.sv @@
// Shared types and constants of the shape record text parser.
// Used by the channel interfaces, the parser core and its checker.
package srtp_pkg;

    localparam int VALUE_WIDTH = 21;
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int ACC_W       = MAG_W + 4;
    localparam int BOUND_W     = 20;
    localparam int CMP_W       = (MAG_W > BOUND_W) ? MAG_W : BOUND_W;
    localparam int CH_W        = 8;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    localparam logic [MAG_W-1:0]   SAT_MAG      = '1;
    localparam logic [BOUND_W-1:0] BOUND_RESET  = BOUND_W'(100000);

    localparam logic [0:0] REG_COORD_BOUND = 1'b0;

    localparam logic [CH_W-1:0] CH_END   = 8'd0;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_HIGH  = 8'd128;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_C     = 8'h43;
    localparam logic [CH_W-1:0] CH_L     = 8'h4C;
    localparam logic [CH_W-1:0] CH_R     = 8'h52;
    localparam logic [CH_W-1:0] CH_S     = 8'h53;

    localparam logic [1:0] KIND_CIRCLE = 2'd0;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_LINE   = 2'd2,
        ST_CIRCLE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        KC_NONE = 3'd0,
        KC_C    = 3'd1,
        KC_L    = 3'd2,
        KC_R    = 3'd3,
        KC_S    = 3'd4
    } t_kind_code;

endpackage

@@ rtl/core/srtp_if.sv @@
// Valid/ready channel interfaces of the shape record text parser.
// Depends on srtp_pkg for field widths and the status type.
interface srtp_byte_if;
    logic                     valid;
    logic                     ready;
    logic [srtp_pkg::CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface srtp_result_if;
    logic                                   valid;
    logic                                   ready;
    srtp_pkg::t_status                      status;
    logic [1:0]                             shape_kind;
    logic signed [srtp_pkg::VALUE_WIDTH-1:0] first_x;
    logic signed [srtp_pkg::VALUE_WIDTH-1:0] first_y;
    logic signed [srtp_pkg::VALUE_WIDTH-1:0] second_x;
    logic signed [srtp_pkg::VALUE_WIDTH-1:0] second_y;
    logic [srtp_pkg::BOUND_W-1:0]           radius;

    modport source (output valid, output status, output shape_kind, output first_x,
                    output first_y, output second_x, output second_y, output radius,
                    input ready);
    modport sink   (input valid, input status, input shape_kind, input first_x,
                    input first_y, input second_x, input second_y, input radius,
                    output ready);
endinterface

@@ rtl/core/shape_record_text_parser_unit.sv @@
// Shape record text parser: byte stream in, one parsed record out per line.
// Depends on srtp_pkg and the channel interfaces in srtp_if.
//
// Usage:
//   i_in carries one text byte per transfer; byte 0 ends the record.
//   o_res carries one result per record: status, kind and the parsed values.
//   The APB port holds coord_bound at byte address 0 (paddr[2] selects the
//   word); writes land in the access cycle, pready is always high.
// Throughput and timing:
//   One byte per cycle unless a terminator waits on a pending result. Each
//   byte updates the parse state as it is taken; a terminator loads the result
//   register, valid in the cycle after the transfer. The per-byte path is one
//   multiply by ten with saturation and the bound and endpoint compares.
// Reset:
//   Synchronous, active low; clears the parse state and the result valid
//   flag and sets coord_bound to 100000.
// Stall:
//   While a result waits, bytes other than the terminator are still taken;
//   a terminator waits until the pending result transfers.
module shape_record_text_parser_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    srtp_byte_if.sink                          i_in,
    srtp_result_if.source                      o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srtp_pkg::PADDR_W-1:0]       paddr,
    input  logic [srtp_pkg::DATA_W-1:0]        pwdata,
    output logic [srtp_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int VW = srtp_pkg::VALUE_WIDTH;
    localparam int MW = srtp_pkg::MAG_W;
    localparam int AW = srtp_pkg::ACC_W;
    localparam int CW = srtp_pkg::CMP_W;
    localparam int BW = srtp_pkg::BOUND_W;

    logic [BW-1:0] r_bound;

    logic [2:0]             r_tok_idx,  n_tok_idx;
    logic                   r_inside,   n_inside;
    srtp_pkg::t_status      r_err,      n_err;
    logic                   r_neg,      n_neg;
    logic [1:0]             r_dig_cnt,  n_dig_cnt;
    logic                   r_lead_zero, n_lead_zero;
    logic [MW-1:0]          r_acc,      n_acc;
    srtp_pkg::t_kind_code   r_kind,     n_kind;
    logic [1:0]             r_kind_len, n_kind_len;
    logic signed [VW-1:0]   r_vals [4];
    logic signed [VW-1:0]   n_vals [4];

    logic                   r_out_valid;
    srtp_pkg::t_status      r_status,   res_status;
    logic [1:0]             r_shape,    res_shape;
    logic signed [VW-1:0]   r_fx,       res_fx;
    logic signed [VW-1:0]   r_fy,       res_fy;
    logic signed [VW-1:0]   r_sx,       res_sx;
    logic signed [VW-1:0]   r_sy,       res_sy;
    logic [BW-1:0]          r_radius,   res_radius;

    logic                   in_fire;
    logic                   is_end;
    logic                   is_sep;
    logic                   is_digit;
    logic                   cfg_write;
    logic [AW-1:0]          acc_ext;
    logic [AW-1:0]          acc_sum;
    logic [3:0]             dig_val;
    logic [2:0]             needed;
    logic [1:0]             st_idx;
    logic signed [VW-1:0]   new_val;
    logic                   first;

    function automatic logic [MW-1:0] mag_of(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    function automatic logic out_of_range(input logic [MW-1:0] m,
                                          input logic [BW-1:0] b);
        return (CW'(m) >= CW'(b)) || (m == srtp_pkg::SAT_MAG);
    endfunction

    function automatic srtp_pkg::t_kind_code kind_of(input logic [srtp_pkg::CH_W-1:0] c);
        srtp_pkg::t_kind_code k;
        case (c)
            srtp_pkg::CH_C: k = srtp_pkg::KC_C;
            srtp_pkg::CH_L: k = srtp_pkg::KC_L;
            srtp_pkg::CH_R: k = srtp_pkg::KC_R;
            srtp_pkg::CH_S: k = srtp_pkg::KC_S;
            default:        k = srtp_pkg::KC_NONE;
        endcase
        return k;
    endfunction

    assign is_end   = (i_in.ch == srtp_pkg::CH_END);
    assign is_sep   = !is_end && ((i_in.ch <= srtp_pkg::CH_SPACE) ||
                                  (i_in.ch >= srtp_pkg::CH_HIGH));
    assign is_digit = (i_in.ch >= srtp_pkg::CH_ZERO) && (i_in.ch <= srtp_pkg::CH_NINE);
    assign dig_val  = 4'(i_in.ch - srtp_pkg::CH_ZERO);

    assign i_in.ready = !r_out_valid || o_res.ready || !is_end;
    assign in_fire    = i_in.valid && i_in.ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[srtp_pkg::PADDR_W-1] == srtp_pkg::REG_COORD_BOUND);
    assign prdata    = (paddr[srtp_pkg::PADDR_W-1] == srtp_pkg::REG_COORD_BOUND) ?
                       srtp_pkg::DATA_W'(r_bound) : '0;

    always_comb begin
        n_tok_idx   = r_tok_idx;
        n_inside    = r_inside;
        n_err       = r_err;
        n_neg       = r_neg;
        n_dig_cnt   = r_dig_cnt;
        n_lead_zero = r_lead_zero;
        n_acc       = r_acc;
        n_kind      = r_kind;
        n_kind_len  = r_kind_len;
        n_vals      = r_vals;
        res_status  = srtp_pkg::ST_OK;
        res_shape   = '0;
        res_fx      = '0;
        res_fy      = '0;
        res_sx      = '0;
        res_sy      = '0;
        res_radius  = '0;
        first       = !r_inside;
        needed      = (r_kind == srtp_pkg::KC_C) ? 3'd4 : 3'd5;
        st_idx      = 2'(r_tok_idx - 3'd1);
        new_val     = r_neg ? -VW'({1'b0, r_acc}) : VW'({1'b0, r_acc});
        acc_ext     = first ? '0 : AW'(r_acc);
        acc_sum     = (acc_ext << 3) + (acc_ext << 1) + AW'(dig_val);

        if (in_fire) begin
            if (!is_end && !is_sep) begin
                n_inside = 1'b1;
                if (first) begin
                    n_neg       = 1'b0;
                    n_dig_cnt   = '0;
                    n_lead_zero = 1'b0;
                    n_acc       = '0;
                    if (r_err == srtp_pkg::ST_OK && r_tok_idx >= 3'd1 &&
                        r_tok_idx >= needed) begin
                        n_err = srtp_pkg::ST_FORMAT;
                    end
                end
                if (n_err == srtp_pkg::ST_OK) begin
                    if (r_tok_idx == 3'd0) begin
                        if (first) begin
                            n_kind = kind_of(i_in.ch);
                        end
                        if (r_kind_len < 2'd2) begin
                            n_kind_len = r_kind_len + 2'd1;
                        end
                    end else if (first && i_in.ch == srtp_pkg::CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (is_digit) begin
                        if (n_lead_zero) begin
                            n_err = srtp_pkg::ST_FORMAT;
                        end else begin
                            if (n_dig_cnt == 2'd0 && i_in.ch == srtp_pkg::CH_ZERO) begin
                                n_lead_zero = 1'b1;
                            end
                            n_acc = (acc_sum > AW'(srtp_pkg::SAT_MAG)) ?
                                    srtp_pkg::SAT_MAG : acc_sum[MW-1:0];
                            if (n_dig_cnt < 2'd2) begin
                                n_dig_cnt = n_dig_cnt + 2'd1;
                            end
                        end
                    end else begin
                        n_err = srtp_pkg::ST_FORMAT;
                    end
                end
            end else if (r_inside) begin
                n_inside = 1'b0;
                if (r_tok_idx < 3'd7) begin
                    n_tok_idx = r_tok_idx + 3'd1;
                end
                if (r_err == srtp_pkg::ST_OK) begin
                    if (r_tok_idx == 3'd0) begin
                        if (r_kind_len != 2'd1 || r_kind == srtp_pkg::KC_NONE) begin
                            n_err = srtp_pkg::ST_FORMAT;
                        end
                    end else if (r_tok_idx < needed) begin
                        if (r_dig_cnt == 2'd0) begin
                            n_err = srtp_pkg::ST_FORMAT;
                        end else begin
                            n_vals[st_idx] = new_val;
                            if (r_tok_idx == 3'd2) begin
                                if (out_of_range(mag_of(r_vals[0]), r_bound) ||
                                    out_of_range(r_acc, r_bound)) begin
                                    n_err = (r_kind == srtp_pkg::KC_C) ?
                                            srtp_pkg::ST_CIRCLE : srtp_pkg::ST_LINE;
                                end
                            end else if (r_tok_idx == 3'd3 && r_kind == srtp_pkg::KC_C) begin
                                if (r_acc == '0 || r_neg || out_of_range(r_acc, r_bound)) begin
                                    n_err = srtp_pkg::ST_CIRCLE;
                                end
                            end else if (r_tok_idx == 3'd4) begin
                                if (out_of_range(mag_of(r_vals[2]), r_bound) ||
                                    out_of_range(r_acc, r_bound)) begin
                                    n_err = srtp_pkg::ST_LINE;
                                end else if (r_vals[0] == r_vals[2] &&
                                             r_vals[1] == new_val) begin
                                    n_err = srtp_pkg::ST_LINE;
                                end
                            end
                        end
                    end
                end
            end

            if (is_end) begin
                if (n_err == srtp_pkg::ST_OK && (n_tok_idx < 3'd3 || n_tok_idx < needed)) begin
                    n_err = srtp_pkg::ST_FORMAT;
                end
                res_status = n_err;
                if (n_err == srtp_pkg::ST_OK) begin
                    res_shape = 2'(n_kind - srtp_pkg::KC_C);
                    res_fx    = n_vals[0];
                    res_fy    = n_vals[1];
                    if (n_kind == srtp_pkg::KC_C) begin
                        res_radius = BW'(unsigned'(n_vals[2]));
                    end else begin
                        res_sx = n_vals[2];
                        res_sy = n_vals[3];
                    end
                end
                n_tok_idx   = '0;
                n_inside    = 1'b0;
                n_err       = srtp_pkg::ST_OK;
                n_neg       = 1'b0;
                n_dig_cnt   = '0;
                n_lead_zero = 1'b0;
                n_acc       = '0;
                n_kind      = srtp_pkg::KC_NONE;
                n_kind_len  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound     <= srtp_pkg::BOUND_RESET;
            r_tok_idx   <= '0;
            r_inside    <= 1'b0;
            r_err       <= srtp_pkg::ST_OK;
            r_neg       <= 1'b0;
            r_dig_cnt   <= '0;
            r_lead_zero <= 1'b0;
            r_acc       <= '0;
            r_kind      <= srtp_pkg::KC_NONE;
            r_kind_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_bound <= pwdata[BW-1:0];
            end
            r_tok_idx   <= n_tok_idx;
            r_inside    <= n_inside;
            r_err       <= n_err;
            r_neg       <= n_neg;
            r_dig_cnt   <= n_dig_cnt;
            r_lead_zero <= n_lead_zero;
            r_acc       <= n_acc;
            r_kind      <= n_kind;
            r_kind_len  <= n_kind_len;
            if (in_fire && is_end) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vals <= n_vals;
        if (in_fire && is_end) begin
            r_status <= res_status;
            r_shape  <= res_shape;
            r_fx     <= res_fx;
            r_fy     <= res_fy;
            r_sx     <= res_sx;
            r_sy     <= res_sy;
            r_radius <= res_radius;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.shape_kind = r_shape;
    assign o_res.first_x    = r_fx;
    assign o_res.first_y    = r_fy;
    assign o_res.second_x   = r_sx;
    assign o_res.second_y   = r_sy;
    assign o_res.radius     = r_radius;

endmodule

@@ rtl/core/srtp_checker.sv @@
// Port-level checker of the shape record text parser, bound to shape_record_text_parser_unit.
// Depends on srtp_pkg for widths and codes.
module srtp_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_in_valid,
    input logic                                    i_in_ready,
    input logic [srtp_pkg::CH_W-1:0]               i_in_ch,
    input logic                                    i_out_valid,
    input logic                                    i_out_ready,
    input srtp_pkg::t_status                       i_status,
    input logic [1:0]                              i_shape_kind,
    input logic signed [srtp_pkg::VALUE_WIDTH-1:0] i_first_x,
    input logic signed [srtp_pkg::VALUE_WIDTH-1:0] i_first_y,
    input logic signed [srtp_pkg::VALUE_WIDTH-1:0] i_second_x,
    input logic signed [srtp_pkg::VALUE_WIDTH-1:0] i_second_y,
    input logic [srtp_pkg::BOUND_W-1:0]            i_radius
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
        $stable(i_first_x) && $stable(i_first_y) && $stable(i_second_x) &&
        $stable(i_second_y) && $stable(i_radius) && $stable(i_shape_kind))
        else $error("result changed while stalled");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_ch == srtp_pkg::CH_END |=> i_out_valid)
        else $error("terminator transfer without result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != srtp_pkg::ST_OK |->
        i_shape_kind == 2'd0 && i_first_x == '0 && i_first_y == '0 &&
        i_second_x == '0 && i_second_y == '0 && i_radius == '0)
        else $error("error result carries values");

    a_circle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == srtp_pkg::ST_OK && i_shape_kind == srtp_pkg::KIND_CIRCLE
        |-> i_radius != '0 && i_second_x == '0 && i_second_y == '0)
        else $error("bad circle result");

    a_line_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == srtp_pkg::ST_OK && i_shape_kind != srtp_pkg::KIND_CIRCLE
        |-> i_radius == '0 && !(i_first_x == i_second_x && i_first_y == i_second_y))
        else $error("bad line result");

endmodule

bind shape_record_text_parser_unit srtp_checker u_srtp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_ch      (i_in.ch),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_shape_kind (o_res.shape_kind),
    .i_first_x    (o_res.first_x),
    .i_first_y    (o_res.first_y),
    .i_second_x   (o_res.second_x),
    .i_second_y   (o_res.second_y),
    .i_radius     (o_res.radius)
);
